// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define I2A_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define I2A_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/i2a_pkg.sv =====
package i2a_pkg;

  localparam int MAG_W      = 64;
  localparam int HALF_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 20;
  localparam int DIG_BITS   = NUM_DIGITS * DIGIT_W;
  localparam int DD_W       = DIG_BITS + MAG_W;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef struct packed {
    logic [MAG_W-1:0] value;
    logic             hex_radix;
    logic             is_signed;
    logic             wide;
  } i2a_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } i2a_out_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic emit_sign;
    logic emit_digit;
    logic pos_dec;
  } i2a_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic digit_zero;
    logic pos_zero;
  } i2a_sts_t;

endpackage

// ===== rtl/core/i2a_dp.sv =====
module i2a_dp (
  input  logic              clk,
  input  i2a_pkg::i2a_in_t  in_data,
  input  i2a_pkg::i2a_cmd_t cmd,
  output i2a_pkg::i2a_sts_t sts,
  output i2a_pkg::i2a_out_t out_data
);
  import i2a_pkg::*;

  localparam int STEP_BITS = 4;
  localparam logic [CNT_W-1:0] CONV_WIDE   = CNT_W'(MAG_W / STEP_BITS);
  localparam logic [CNT_W-1:0] CONV_NARROW = CNT_W'(HALF_W / STEP_BITS);
  localparam logic [POS_W-1:0] POS_DEC_WIDE   = POS_W'(NUM_DIGITS - 1);
  localparam logic [POS_W-1:0] POS_DEC_NARROW = POS_W'(NUM_DIGITS / 2 - 1);
  localparam logic [POS_W-1:0] POS_HEX_WIDE   = POS_W'(MAG_W / DIGIT_W - 1);
  localparam logic [POS_W-1:0] POS_HEX_NARROW = POS_W'(HALF_W / DIGIT_W - 1);
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_BASE = 7'h57;

  logic [DIG_BITS-1:0] dig_r, dig_nxt;
  logic [MAG_W-1:0]    bin_r, bin_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                neg_r, neg_nxt;
  i2a_out_t            out_r, out_nxt;

  logic [MAG_W-1:0]    mag;
  logic                neg;
  logic [DD_W-1:0]     dd;
  logic [DIGIT_W-1:0]  cur_digit;

  // one double-dabble bit: add 3 to every digit of 5 or more, then shift
  function automatic logic [DD_W-1:0] dd_shift(input logic [DD_W-1:0] v);
    logic [DD_W-1:0] t;
    t = v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (t[MAG_W + DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
        t[MAG_W + DIGIT_W*i +: DIGIT_W] = t[MAG_W + DIGIT_W*i +: DIGIT_W] + 4'd3;
      end
    end
    return {t[DD_W-2:0], 1'b0};
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {3'b000, d};
    end
    return CHAR_A_BASE + {3'b000, d};
  endfunction

  assign cur_digit = dig_r[{pos_r, 2'b00} +: DIGIT_W];

  always_comb begin
    neg = in_data.is_signed & (in_data.wide ? in_data.value[MAG_W-1]
                                            : in_data.value[HALF_W-1]);
    if (in_data.wide) begin
      mag = neg ? (64'd0 - in_data.value) : in_data.value;
    end else begin
      mag = {32'd0, neg ? (32'd0 - in_data.value[HALF_W-1:0]) : in_data.value[HALF_W-1:0]};
    end
  end

  always_comb begin
    dd = {dig_r, bin_r};
    for (int s = 0; s < STEP_BITS; s++) begin
      dd = dd_shift(dd);
    end
  end

  always_comb begin
    dig_nxt = dig_r;
    bin_nxt = bin_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    neg_nxt = neg_r;
    out_nxt = out_r;
    if (cmd.load) begin
      neg_nxt = neg;
      if (in_data.hex_radix) begin
        dig_nxt = {{(DIG_BITS-MAG_W){1'b0}}, mag};
        bin_nxt = '0;
        cnt_nxt = '0;
        pos_nxt = in_data.wide ? POS_HEX_WIDE : POS_HEX_NARROW;
      end else begin
        dig_nxt = '0;
        bin_nxt = in_data.wide ? mag : {mag[HALF_W-1:0], 32'd0};
        cnt_nxt = in_data.wide ? CONV_WIDE : CONV_NARROW;
        pos_nxt = in_data.wide ? POS_DEC_WIDE : POS_DEC_NARROW;
      end
    end
    if (cmd.conv) begin
      dig_nxt = dd[DD_W-1:MAG_W];
      bin_nxt = dd[MAG_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.pos_dec) begin
      pos_nxt = pos_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_nxt.character = CHAR_MINUS;
      out_nxt.last_char = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_nxt.character = digit_char(cur_digit);
      out_nxt.last_char = (pos_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  assign sts.conv_done  = (cnt_r == '0);
  assign sts.neg        = neg_r;
  assign sts.digit_zero = (cur_digit == '0);
  assign sts.pos_zero   = (pos_r == '0);
  assign out_data       = out_r;

endmodule

// ===== rtl/core/i2a_ctrl.sv =====
module i2a_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  i2a_pkg::i2a_sts_t sts,
  output i2a_pkg::i2a_cmd_t cmd
);
  import i2a_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   started_r, started_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          started_nxt = 1'b0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        if (sts.conv_done) begin
          state_nxt = sts.neg ? S_SIGN : S_EMIT;
        end else begin
          cmd.conv = 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          cmd.emit_sign = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        // leading zeros are skipped, a lone zero digit is kept
        if (!started_r && sts.digit_zero && !sts.pos_zero) begin
          cmd.pos_dec = 1'b1;
        end else if (out_free) begin
          cmd.emit_digit = 1'b1;
          out_valid_nxt  = 1'b1;
          started_nxt    = 1'b1;
          if (sts.pos_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/integer_to_ascii_digits.sv =====
// integer_to_ascii_digits: one integer in, its ASCII text out, one character per
// output transfer, most significant first.
// input channel in_valid/in_ready/in_data carries value, hex_radix, is_signed
// and wide; the result channel out_valid/out_ready/out_data carries character
// and last_char, set on the final character of each number.
// a request is taken only while the block is idle. decimal conversion runs a
// double-dabble unit that shifts four bits per cycle until its step counter,
// loaded from the operand width (64 or 32 bits), runs out; hex skips the
// shifting and only passes through the conversion state.
// emission then walks the digit positions one per cycle while the receiver
// keeps up (20 or 10 decimal, 16 or 8 hex), skipping leading zeros, after a
// minus sign for a negative signed value. each request runs to its last
// character before the next is taken: the next request can be accepted in
// the cycle after the last character enters the output register.
// the result sits in an output register: when the receiver stalls, the
// character is held and emission pauses, but the last character may still
// wait there while the next request is taken.
// synchronous active-low reset returns the controller to idle and drops
// out_valid; no other state survives between requests.
module integer_to_ascii_digits (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2a_pkg::i2a_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2a_pkg::i2a_out_t out_data
);
  import i2a_pkg::*;

  i2a_cmd_t cmd;
  i2a_sts_t sts;

  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2a_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/i2a_chk.sv =====
`include "assert_macros.svh"

module i2a_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input i2a_pkg::i2a_out_t out_data
);
  import i2a_pkg::*;

  `I2A_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `I2A_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")
  `I2A_ASSERT(a_minus_not_last, out_valid && out_data.character == CHAR_MINUS |-> !out_data.last_char, "minus flagged last")
  `I2A_ASSERT(a_no_accept_mid_number, out_valid && !out_data.last_char |-> !in_ready, "accept before number finished")
  `I2A_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind integer_to_ascii_digits i2a_chk u_chk (.*);
